>>> rtl/sla_pkg.sv
// Shared types, codes and constants for the status LED animator.
// No dependencies; imported by every module of the block.
package sla_pkg;

  // Width of the wrapping millisecond time base
  localparam int TIME_BITS = 32;

  localparam int NOW_BITS  = 32;
  localparam int MODE_BITS = 3;
  localparam int CFG_BITS  = 16;
  localparam int IDX_BITS  = 2;
  localparam int PIX_BITS  = 32;

  // Item action codes
  localparam logic ACT_SET  = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  // Display modes (codes 5..7 are accepted but show nothing)
  localparam logic [MODE_BITS-1:0] MODE_BOOT     = 3'd0;
  localparam logic [MODE_BITS-1:0] MODE_READY    = 3'd1;
  localparam logic [MODE_BITS-1:0] MODE_ACTIVE   = 3'd2;
  localparam logic [MODE_BITS-1:0] MODE_CENTERED = 3'd3;
  localparam logic [MODE_BITS-1:0] MODE_FAILSAFE = 3'd4;

  // Configuration register indexes
  localparam logic [IDX_BITS-1:0] CFG_UPDATE_PERIOD = 2'd0;
  localparam logic [IDX_BITS-1:0] CFG_FLASH_BRIGHT  = 2'd1;
  localparam logic [IDX_BITS-1:0] CFG_FLASH_TOTAL   = 2'd2;

  // Configuration reset values
  localparam logic [CFG_BITS-1:0] RST_UPDATE_PERIOD = 16'd20;
  localparam logic [CFG_BITS-1:0] RST_FLASH_BRIGHT  = 16'd200;
  localparam logic [CFG_BITS-1:0] RST_FLASH_TOTAL   = 16'd400;

  // Colour levels and pulse shape
  localparam logic [7:0] LVL_WHITE_DIM = 8'd6;
  localparam logic [7:0] LVL_GREEN_DIM = 8'd20;
  localparam logic [7:0] LVL_GREEN_HI  = 8'd120;
  localparam logic [7:0] LVL_RED       = 8'd60;
  localparam logic [7:0] PHASE_STEP    = 8'd4;
  localparam logic [7:0] PHASE_HALF    = 8'd128;
  localparam logic [7:0] PHASE_TOP     = 8'd255;

  typedef struct packed {
    logic [CFG_BITS-1:0] update_period;
    logic [CFG_BITS-1:0] flash_bright;
    logic [CFG_BITS-1:0] flash_total;
  } cfg_t;

  typedef struct packed {
    logic [MODE_BITS-1:0] mode;
    logic [TIME_BITS-1:0] last_update;
    logic [TIME_BITS-1:0] flash_start;
    logic [7:0]           phase;
  } state_t;

  // Pack a colour into the GRB output word, low byte zero
  function automatic logic [PIX_BITS-1:0] grb(input logic [7:0] r, input logic [7:0] g,
                                              input logic [7:0] b);
    grb = {g, r, b, 8'h00};
  endfunction

endpackage

>>> rtl/sla_step.sv
// Next-state and colour logic for one accepted item.
// Depends on sla_pkg.
module sla_step (
  input  sla_pkg::state_t                  state_i,
  input  sla_pkg::cfg_t                    cfg_i,
  input  logic                             action_i,
  input  logic [sla_pkg::MODE_BITS-1:0]    new_mode_i,
  input  logic [sla_pkg::NOW_BITS-1:0]     now_ms_i,
  output sla_pkg::state_t                  state_o,
  output logic                             emit_o,
  output logic [sla_pkg::PIX_BITS-1:0]     pixel_o
);
  import sla_pkg::*;

  logic [TIME_BITS-1:0] now;
  logic [TIME_BITS-1:0] since_update;
  logic [TIME_BITS-1:0] flash_base;
  logic [TIME_BITS-1:0] since_flash;
  logic [7:0]           phase_adv;
  logic [7:0]           pulse;
  logic                 due;

  // Time base, cut or widened to TIME_BITS
  assign now          = TIME_BITS'(now_ms_i);
  assign since_update = now - state_i.last_update;
  assign due          = since_update >= TIME_BITS'(cfg_i.update_period);

  // Flash timing: an unarmed flash starts at this tick
  assign flash_base  = (state_i.flash_start == '0) ? now : state_i.flash_start;
  assign since_flash = now - flash_base;

  // Triangular blue pulse
  assign phase_adv = state_i.phase + PHASE_STEP;
  assign pulse     = (phase_adv < PHASE_HALF) ? (phase_adv >> 2) : ((PHASE_TOP - phase_adv) >> 2);

  always_comb begin
    state_o = state_i;
    emit_o  = 1'b0;
    pixel_o = '0;
    if (action_i == ACT_SET) begin
      state_o.mode = new_mode_i;
    end else if (due) begin
      state_o.last_update = now;
      case (state_i.mode)
        MODE_BOOT: begin
          state_o.phase = phase_adv;
          emit_o        = 1'b1;
          pixel_o       = grb(8'd0, 8'd0, pulse);
        end
        MODE_READY: begin
          emit_o  = 1'b1;
          pixel_o = grb(LVL_WHITE_DIM, LVL_WHITE_DIM, LVL_WHITE_DIM);
        end
        MODE_ACTIVE: begin
          emit_o  = 1'b1;
          pixel_o = grb(8'd0, LVL_GREEN_DIM, 8'd0);
        end
        MODE_CENTERED: begin
          state_o.flash_start = flash_base;
          if (since_flash < TIME_BITS'(cfg_i.flash_bright)) begin
            emit_o  = 1'b1;
            pixel_o = grb(8'd0, LVL_GREEN_HI, 8'd0);
          end else if (since_flash < TIME_BITS'(cfg_i.flash_total)) begin
            emit_o  = 1'b1;
            pixel_o = grb(8'd0, LVL_GREEN_DIM, 8'd0);
          end else begin
            // flash over: disarm and fall back to active, silently
            state_o.flash_start = '0;
            state_o.mode        = MODE_ACTIVE;
          end
        end
        MODE_FAILSAFE: begin
          emit_o  = 1'b1;
          pixel_o = grb(LVL_RED, 8'd0, 8'd0);
        end
        default: begin
          // unknown mode: time recorded, nothing shown
        end
      endcase
    end
  end

endmodule

>>> rtl/sla_out_buf.sv
// Two-entry result buffer between the step logic and the output channel.
// Depends on sla_pkg.
module sla_out_buf (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push_i,
  input  logic [sla_pkg::PIX_BITS-1:0]  data_i,
  output logic                          full_o,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [sla_pkg::PIX_BITS-1:0]  out_pixel_word
);
  import sla_pkg::*;

  logic                v0_r, v0_nxt;
  logic                v1_r, v1_nxt;
  logic [PIX_BITS-1:0] d0_r, d0_nxt;
  logic [PIX_BITS-1:0] d1_r, d1_nxt;
  logic                pop;

  assign pop            = v0_r && out_ready;
  assign full_o         = v1_r;
  assign out_valid      = v0_r;
  assign out_pixel_word = d0_r;

  // Head/tail update
  always_comb begin
    v0_nxt = v0_r;
    v1_nxt = v1_r;
    d0_nxt = d0_r;
    d1_nxt = d1_r;
    if (pop) begin
      if (v1_r) begin
        d0_nxt = d1_r;
        if (push_i) begin
          d1_nxt = data_i;
        end else begin
          v1_nxt = 1'b0;
        end
      end else if (push_i) begin
        d0_nxt = data_i;
      end else begin
        v0_nxt = 1'b0;
      end
    end else if (push_i) begin
      if (!v0_r) begin
        d0_nxt = data_i;
        v0_nxt = 1'b1;
      end else begin
        d1_nxt = data_i;
        v1_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
    end else begin
      v0_r <= v0_nxt;
      v1_r <= v1_nxt;
    end
    d0_r <= d0_nxt;
    d1_r <= d1_nxt;
  end

  // Tail is only ever occupied behind a valid head
  a_tail_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r |-> v0_r) else $error("tail valid without head");

  // No push into a full buffer
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push_i |-> !v1_r) else $error("push into full result buffer");

  // A stalled head item holds its value
  a_head_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (v0_r && !out_ready) |=> (v0_r && d0_r == $past(d0_r))) else $error("stalled head changed");

endmodule

>>> rtl/status_led_animator_unit.sv
// Status LED animator: one item handled per cycle, no result for set items.
// A tick item's result is registered into the result buffer as the item is accepted.
// Throughput: one item per cycle; the two-entry result buffer stalls input only
// when both entries wait on the output channel.
// Reset (synchronous, rst_n low): boot mode, times and phase zero, registers at defaults.
// Depends on sla_pkg, sla_step and sla_out_buf.
module status_led_animator_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [sla_pkg::IDX_BITS-1:0]   cfg_index,
  input  logic [sla_pkg::CFG_BITS-1:0]   cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_action,
  input  logic [sla_pkg::MODE_BITS-1:0]  in_new_mode,
  input  logic [sla_pkg::NOW_BITS-1:0]   in_now_ms,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [sla_pkg::PIX_BITS-1:0]   out_pixel_word
);
  import sla_pkg::*;

  cfg_t                cfg_r, cfg_nxt;
  state_t              state_r, state_nxt;
  state_t              step_state;
  logic                step_emit;
  logic [PIX_BITS-1:0] step_pixel;
  logic                buf_full;
  logic                in_accept;

  assign in_ready  = !buf_full;
  assign in_accept = in_valid && in_ready;

  // Configuration writes; unknown indexes ignored
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_UPDATE_PERIOD: cfg_nxt.update_period = cfg_wdata;
        CFG_FLASH_BRIGHT:  cfg_nxt.flash_bright  = cfg_wdata;
        CFG_FLASH_TOTAL:   cfg_nxt.flash_total   = cfg_wdata;
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  // Per-item logic
  sla_step u_step (
    .state_i    (state_r),
    .cfg_i      (cfg_r),
    .action_i   (in_action),
    .new_mode_i (in_new_mode),
    .now_ms_i   (in_now_ms),
    .state_o    (step_state),
    .emit_o     (step_emit),
    .pixel_o    (step_pixel)
  );

  assign state_nxt = in_accept ? step_state : state_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.update_period <= RST_UPDATE_PERIOD;
      cfg_r.flash_bright  <= RST_FLASH_BRIGHT;
      cfg_r.flash_total   <= RST_FLASH_TOTAL;
      state_r             <= '0;
    end else begin
      cfg_r   <= cfg_nxt;
      state_r <= state_nxt;
    end
  end

  // Result buffer
  sla_out_buf u_out_buf (
    .clk            (clk),
    .rst_n          (rst_n),
    .push_i         (in_accept && step_emit),
    .data_i         (step_pixel),
    .full_o         (buf_full),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_pixel_word (out_pixel_word)
  );

  // A set item only changes the mode
  a_set_keeps_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_action == ACT_SET) |=>
      (state_r.last_update == $past(state_r.last_update) &&
       state_r.mode == $past(in_new_mode))) else $error("set item disturbed state");

  // Set items never produce a result
  a_set_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_action == ACT_SET) |-> !step_emit) else $error("set item emitted a result");

  // Disarming the flash always lands in active mode
  a_disarm_active: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_action == ACT_TICK && state_r.flash_start != '0 &&
     step_state.flash_start == '0) |-> (step_state.mode == MODE_ACTIVE))
    else $error("flash disarmed outside flash end");

endmodule
